[rtl/mpsp_pkg.sv]
`default_nettype none

package mpsp_pkg;

    localparam logic [7:0] MARK_FRAME = 8'h34;
    localparam logic [7:0] MARK_ROW   = 8'h33;
    localparam logic [7:0] MARK_RED   = 8'h32;
    localparam logic [7:0] MARK_GREEN = 8'h31;
    localparam logic [7:0] MARK_BLUE  = 8'h30;
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] LEVEL_BASE = 8'h3A;

    localparam logic [0:0] REG_START_COLUMN = 1'b0;
    localparam logic [0:0] REG_START_ROW    = 1'b1;

    localparam logic [9:0] START_RESET = 10'd400;

    // ceil(2^21 / 31); exact for dividends below 72000.
    localparam logic [16:0] RECIP_31 = 17'd67651;

    typedef struct packed {
        logic [9:0] start_column;
        logic [9:0] start_row;
    } t_cfg;

    typedef struct packed {
        logic [9:0] pixel_column;
        logic [9:0] pixel_row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    // (b - 58) * 255 / 31, truncated, clamped to 0..255.
    function automatic logic [7:0] scale_level(input logic [7:0] b);
        logic [7:0]  d;
        logic [12:0] x;
        logic [29:0] p;
        d = b - LEVEL_BASE;
        x = {d[4:0], 8'b0} - {8'b0, d[4:0]};
        p = {17'b0, x} * {13'b0, RECIP_31};
        if (b <= LEVEL_BASE) begin
            scale_level = 8'd0;
        end else if (d > 8'd31) begin
            scale_level = 8'd255;
        end else begin
            scale_level = p[28:21];
        end
    endfunction

endpackage

`default_nettype wire

[rtl/mpsp_if.sv]
`default_nettype none

interface mpsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mpsp_pixel_if;
    logic       valid;
    logic       ready;
    logic [9:0] pixel_column;
    logic [9:0] pixel_row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, output pixel_column, output pixel_row,
                    output red, output green, output blue, input ready);
    modport sink   (input valid, input pixel_column, input pixel_row,
                    input red, input green, input blue, output ready);
endinterface

interface mpsp_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [9:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/mpsp_cfg.sv]
`default_nettype none

module mpsp_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire logic [0:0]    i_index,
    input  wire logic [9:0]    i_data,
    output mpsp_pkg::t_cfg     o_cfg
);
    import mpsp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_column <= START_RESET;
            r_cfg.start_row    <= START_RESET;
        end else if (i_wr) begin
            case (i_index)
                REG_START_COLUMN: r_cfg.start_column <= i_data;
                REG_START_ROW:    r_cfg.start_row    <= i_data;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/mpsp_core.sv]
`default_nettype none

module mpsp_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic [7:0]    i_byte,
    input  wire mpsp_pkg::t_cfg i_cfg,
    output logic               o_emit,
    output mpsp_pkg::t_pixel   o_pixel
);
    import mpsp_pkg::*;

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_FRAME = 3'd1;
    localparam logic [2:0] MODE_RED   = 3'd2;
    localparam logic [2:0] MODE_GREEN = 3'd3;
    localparam logic [2:0] MODE_BLUE  = 3'd4;

    logic [2:0] r_mode, n_mode;
    logic [9:0] r_col, n_col;
    logic [9:0] r_row, n_row;
    logic [7:0] r_red, n_red;
    logic [7:0] r_green, n_green;
    logic [7:0] r_blue, n_blue;
    logic [7:0] level;
    logic       skip;
    logic       emit;

    assign level = scale_level(i_byte);
    assign skip  = (i_byte == BYTE_LF) || (i_byte == BYTE_CR);

    always_comb begin
        n_mode  = r_mode;
        n_col   = r_col;
        n_row   = r_row;
        n_red   = r_red;
        n_green = r_green;
        n_blue  = r_blue;
        emit    = 1'b0;
        if (r_mode == MODE_IDLE) begin
            if (i_byte == MARK_FRAME) begin
                n_col  = i_cfg.start_column;
                n_row  = i_cfg.start_row;
                n_mode = MODE_FRAME;
            end
        end else if (!skip) begin
            case (r_mode)
                MODE_RED: begin
                    n_red  = level;
                    n_mode = MODE_FRAME;
                end
                MODE_GREEN: begin
                    n_green = level;
                    n_mode  = MODE_FRAME;
                end
                MODE_BLUE: begin
                    n_blue = level;
                    n_mode = MODE_FRAME;
                    emit   = 1'b1;
                end
                default: begin
                    case (i_byte)
                        MARK_FRAME: n_mode = MODE_IDLE;
                        MARK_ROW: begin
                            n_col = i_cfg.start_column;
                            if (r_row == 10'd0) begin
                                n_mode = MODE_IDLE;
                            end else begin
                                n_row = r_row - 10'd1;
                            end
                        end
                        MARK_RED:   n_mode = MODE_RED;
                        MARK_GREEN: n_mode = MODE_GREEN;
                        MARK_BLUE:  n_mode = MODE_BLUE;
                        default: begin
                            n_red   = level;
                            n_green = level;
                            n_blue  = level;
                            emit    = 1'b1;
                        end
                    endcase
                end
            endcase
        end
        // A pixel at column zero closes the frame; the pixel still goes out.
        if (emit) begin
            if (r_col == 10'd0) begin
                n_mode = MODE_IDLE;
            end else begin
                n_col = r_col - 10'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_col   <= 10'd0;
            r_row   <= 10'd0;
            r_red   <= 8'd0;
            r_green <= 8'd0;
            r_blue  <= 8'd0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_col   <= n_col;
            r_row   <= n_row;
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_emit               = emit;
    assign o_pixel.pixel_column = r_col;
    assign o_pixel.pixel_row    = r_row;
    assign o_pixel.red          = n_red;
    assign o_pixel.green        = n_green;
    assign o_pixel.blue         = n_blue;

endmodule

`default_nettype wire

[rtl/marked_pixel_stream_parser.sv]
// Marked pixel stream parser.
//
// i_rx carries one received byte per beat; o_px carries one rebuilt pixel
// (column, row, red, green, blue) per beat; i_cfg writes start_column
// (index 0) and start_row (index 1) and is always ready.
//
// A byte is captured in an input register and decoded by the parse state
// machine once the output can take any pixel it makes; that pixel lands
// in the output register at the end of the cycle in which the byte is
// decoded, and o_px valid is driven from that register.
// One byte is taken every cycle while no pixel-making byte waits on a
// stalled o_px; the parse state is updated as each byte is decoded.
//
// Reset clears the parser to idle (waiting for a frame marker), the counters
// and levels to zero, and both start registers to 400.
// When o_px is stalled with a pixel waiting, bytes that make no pixel still
// drain; a byte that makes a pixel holds in the input register and i_rx
// ready drops until the pending pixel is taken.
`default_nettype none

module marked_pixel_stream_parser (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    mpsp_byte_if.sink     i_rx,
    mpsp_pixel_if.source  o_px,
    mpsp_cfg_if.sink      i_cfg
);
    import mpsp_pkg::*;

    t_cfg       cfg;
    t_pixel     pixel;
    logic       emit;
    logic       adv;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_pixel     r_out;

    mpsp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    mpsp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (adv),
        .i_byte  (r_in_byte),
        .i_cfg   (cfg),
        .o_emit  (emit),
        .o_pixel (pixel)
    );

    assign i_cfg.ready = 1'b1;

    assign adv        = r_in_valid && (!emit || !r_out_valid || o_px.ready);
    assign i_rx.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_px.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_out <= pixel;
        end
    end

    assign o_px.valid        = r_out_valid;
    assign o_px.pixel_column = r_out.pixel_column;
    assign o_px.pixel_row    = r_out.pixel_row;
    assign o_px.red          = r_out.red;
    assign o_px.green        = r_out.green;
    assign o_px.blue         = r_out.blue;

    // A held byte must not change under the parser.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held input byte changed");

    // A pixel-making byte never advances over an untaken pixel.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && emit && r_out_valid && !o_px.ready) |-> !adv)
        else $error("pixel overwritten in output register");

    // A new pixel only appears after a byte was parsed.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("pixel appeared without a parsed byte");

endmodule

`default_nettype wire

[tb/marked_pixel_stream_parser_test.sv]
module marked_pixel_stream_parser_test;
    import mpsp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_LIMIT = 2000;
    localparam int TAIL_CYCLES = 4;
    localparam int PHASES = 8;
    localparam int PHASE_BYTES = 150;

    typedef enum logic [2:0] {
        PARSE_IDLE,
        PARSE_FRAME,
        PARSE_RED,
        PARSE_GREEN,
        PARSE_BLUE
    } t_parse_mode;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_SETUP
    } t_step_kind;

    typedef enum logic [1:0] {
        WANT_MODEL,
        WANT_NONE,
        WANT_PIXEL
    } t_want;

    typedef struct packed {
        t_step_kind kind;
        logic [7:0] rx;
        t_want      want;
        t_pixel     px;
        logic [9:0] set_col;
        logic [9:0] set_row;
    } t_script_row;

    localparam t_pixel NO_PX = '0;

    logic i_clk;
    logic i_rst_n;

    mpsp_byte_if  rx_if ();
    mpsp_pixel_if px_if ();
    mpsp_cfg_if   cfg_if ();

    marked_pixel_stream_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_px    (px_if),
        .i_cfg   (cfg_if)
    );

    // Parser state as the block should hold it.
    t_parse_mode parser_mode;
    logic [10:0] col_left;
    logic [10:0] row_left;
    logic [7:0]  red_now;
    logic [7:0]  green_now;
    logic [7:0]  blue_now;
    logic [9:0]  start_col_cfg;
    logic [9:0]  start_row_cfg;

    t_pixel pending_pixels[$];
    int     fail_count;
    int     cycle_count;
    int     pixel_stall;
    bit     calm_stretch;

    t_script_row script [0:28] = '{
        '{ROW_BYTE, 8'h41, WANT_NONE, NO_PX, 10'd0, 10'd0},
        '{ROW_BYTE, MARK_FRAME, WANT_NONE, NO_PX, 10'd0, 10'd0},
        '{ROW_BYTE, BYTE_LF, WANT_NONE, NO_PX, 10'd0, 10'd0},
        '{ROW_BYTE, 8'h00, WANT_PIXEL, '{10'd400, 10'd400, 8'd0, 8'd0, 8'd0}, 10'd0, 10'd0},
        '{ROW_BYTE, 8'hFF, WANT_PIXEL, '{10'd399, 10'd400, 8'd255, 8'd255, 8'd255},
          10'd0, 10'd0},
        '{ROW_BYTE, LEVEL_BASE, WANT_PIXEL, '{10'd398, 10'd400, 8'd0, 8'd0, 8'd0},
          10'd0, 10'd0},
        '{ROW_BYTE, 8'h59, WANT_MODEL, NO_PX, 10'd0, 10'd0},
        '{ROW_BYTE, 8'h5A, WANT_MODEL, NO_PX, 10'd0, 10'd0},
        '{ROW_BYTE, MARK_RED, WANT_NONE, NO_PX, 10'd0, 10'd0},
        '{ROW_BYTE, BYTE_CR, WANT_NONE, NO_PX, 10'd0, 10'd0},
        // The frame marker after a channel marker and a skipped CR is a level value.
        '{ROW_BYTE, MARK_FRAME, WANT_NONE, NO_PX, 10'd0, 10'd0},
        '{ROW_BYTE, MARK_GREEN, WANT_NONE, NO_PX, 10'd0, 10'd0},
        '{ROW_BYTE, 8'h45, WANT_NONE, NO_PX, 10'd0, 10'd0},
        '{ROW_BYTE, MARK_BLUE, WANT_NONE, NO_PX, 10'd0, 10'd0},
        '{ROW_BYTE, MARK_ROW, WANT_MODEL, NO_PX, 10'd0, 10'd0},
        '{ROW_BYTE, MARK_ROW, WANT_NONE, NO_PX, 10'd0, 10'd0},
        // The closing frame marker must not open a new frame.
        '{ROW_BYTE, MARK_FRAME, WANT_NONE, NO_PX, 10'd0, 10'd0},
        '{ROW_BYTE, 8'h00, WANT_NONE, NO_PX, 10'd0, 10'd0},
        '{ROW_BYTE, MARK_FRAME, WANT_NONE, NO_PX, 10'd0, 10'd0},
        // New start values written mid-frame: the row marker reloads only the column.
        '{ROW_SETUP, 8'h00, WANT_NONE, NO_PX, 10'd0, 10'd0},
        '{ROW_BYTE, MARK_ROW, WANT_NONE, NO_PX, 10'd0, 10'd0},
        '{ROW_BYTE, MARK_BLUE, WANT_NONE, NO_PX, 10'd0, 10'd0},
        '{ROW_BYTE, 8'h80, WANT_MODEL, NO_PX, 10'd0, 10'd0},
        '{ROW_BYTE, 8'h80, WANT_NONE, NO_PX, 10'd0, 10'd0},
        '{ROW_BYTE, MARK_FRAME, WANT_NONE, NO_PX, 10'd0, 10'd0},
        '{ROW_BYTE, 8'h80, WANT_PIXEL, '{10'd0, 10'd0, 8'd255, 8'd255, 8'd255}, 10'd0, 10'd0},
        '{ROW_BYTE, MARK_FRAME, WANT_NONE, NO_PX, 10'd0, 10'd0},
        '{ROW_BYTE, MARK_ROW, WANT_NONE, NO_PX, 10'd0, 10'd0},
        '{ROW_BYTE, 8'h80, WANT_NONE, NO_PX, 10'd0, 10'd0}
    };

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int idle_cycles();
        if (calm_stretch) begin
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    function automatic logic [7:0] byte_to_level(input logic [7:0] b);
        int scaled;
        if (b <= LEVEL_BASE) begin
            return 8'd0;
        end
        scaled = (int'(b) - int'(LEVEL_BASE)) * 255 / 31;
        return (scaled > 255) ? 8'd255 : 8'(scaled);
    endfunction

    // Moves the parser state by one byte; returns 1 when the byte makes a pixel.
    function automatic bit advance_parser(input logic [7:0] b, output t_pixel px);
        px = '0;
        if (parser_mode == PARSE_IDLE) begin
            if (b == MARK_FRAME) begin
                col_left = {1'b0, start_col_cfg};
                row_left = {1'b0, start_row_cfg};
                parser_mode = PARSE_FRAME;
            end
            return 1'b0;
        end
        if (b == BYTE_LF || b == BYTE_CR) begin
            return 1'b0;
        end
        case (parser_mode)
            PARSE_RED: begin
                red_now = byte_to_level(b);
                parser_mode = PARSE_FRAME;
                return 1'b0;
            end
            PARSE_GREEN: begin
                green_now = byte_to_level(b);
                parser_mode = PARSE_FRAME;
                return 1'b0;
            end
            PARSE_BLUE: begin
                blue_now = byte_to_level(b);
                parser_mode = PARSE_FRAME;
            end
            default: begin
                if (b == MARK_FRAME) begin
                    parser_mode = PARSE_IDLE;
                    return 1'b0;
                end
                if (b == MARK_ROW) begin
                    col_left = {1'b0, start_col_cfg};
                    if (row_left == 0) begin
                        parser_mode = PARSE_IDLE;
                    end else begin
                        row_left--;
                    end
                    return 1'b0;
                end
                if (b == MARK_RED) begin
                    parser_mode = PARSE_RED;
                    return 1'b0;
                end
                if (b == MARK_GREEN) begin
                    parser_mode = PARSE_GREEN;
                    return 1'b0;
                end
                if (b == MARK_BLUE) begin
                    parser_mode = PARSE_BLUE;
                    return 1'b0;
                end
                red_now = byte_to_level(b);
                green_now = red_now;
                blue_now = red_now;
            end
        endcase
        px = '{col_left[9:0], row_left[9:0], red_now, green_now, blue_now};
        // A pixel at column zero closes the frame instead of decrementing the counter.
        if (col_left == 0) begin
            parser_mode = PARSE_IDLE;
        end else begin
            col_left--;
        end
        return 1'b1;
    endfunction

    // Mostly well-formed frames, with some noise and broken channel sequences.
    function automatic logic [7:0] pick_rx_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        case (parser_mode)
            PARSE_IDLE: begin
                return (r < 60) ? MARK_FRAME : 8'($urandom);
            end
            PARSE_FRAME: begin
                if (r < 3) return MARK_FRAME;
                if (r < 10) return MARK_ROW;
                if (r < 16) return MARK_RED;
                if (r < 22) return MARK_GREEN;
                if (r < 30) return MARK_BLUE;
                if (r < 34) return BYTE_LF;
                if (r < 38) return BYTE_CR;
                if (r < 70) return 8'($urandom_range(int'(LEVEL_BASE), int'(LEVEL_BASE) + 33));
                return 8'($urandom);
            end
            default: begin
                if (r < 4) return BYTE_LF;
                if (r < 8) return BYTE_CR;
                if (r < 50) return 8'($urandom_range(int'(LEVEL_BASE), int'(LEVEL_BASE) + 33));
                return 8'($urandom);
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input t_want want, input t_pixel typed);
        int     gap;
        t_pixel px;
        bit     made;
        gap = idle_cycles();
        if (gap != 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        made = advance_parser(b, px);
        case (want)
            WANT_MODEL: begin
                if (made) begin
                    pending_pixels.push_back(px);
                end
            end
            WANT_PIXEL: pending_pixels.push_back(typed);
            default: ;
        endcase
    endtask

    // Waits for the last pixel, then for bytes still in flight that make none.
    task automatic settle();
        int waited;
        waited = 0;
        rx_if.valid <= 1'b0;
        while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_starts(input logic [9:0] col, input logic [9:0] row);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= REG_START_COLUMN;
        cfg_if.data <= col;
        do @(posedge i_clk); while (!cfg_if.ready);
        start_col_cfg = col;
        cfg_if.index <= REG_START_ROW;
        cfg_if.data <= row;
        do @(posedge i_clk); while (!cfg_if.ready);
        start_row_cfg = row;
        cfg_if.valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        t_pixel got;
        if (!i_rst_n) begin
            pixel_stall = 0;
            px_if.ready <= 1'b0;
        end else begin
            if (px_if.valid && px_if.ready) begin
                got = '{px_if.pixel_column, px_if.pixel_row, px_if.red, px_if.green,
                        px_if.blue};
                if (pending_pixels.size() == 0) begin
                    $error("pixel beat with none expected: column %0d row %0d",
                           got.pixel_column, got.pixel_row);
                    fail_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.pixel_column !== want.pixel_column) begin
                        $error("pixel_column: expected %0d, got %0d",
                               want.pixel_column, got.pixel_column);
                        fail_count++;
                    end
                    if (got.pixel_row !== want.pixel_row) begin
                        $error("pixel_row: expected %0d, got %0d",
                               want.pixel_row, got.pixel_row);
                        fail_count++;
                    end
                    if (got.red !== want.red) begin
                        $error("red: expected %0d, got %0d", want.red, got.red);
                        fail_count++;
                    end
                    if (got.green !== want.green) begin
                        $error("green: expected %0d, got %0d", want.green, got.green);
                        fail_count++;
                    end
                    if (got.blue !== want.blue) begin
                        $error("blue: expected %0d, got %0d", want.blue, got.blue);
                        fail_count++;
                    end
                end
                pixel_stall = idle_cycles();
            end else if (pixel_stall != 0) begin
                pixel_stall--;
            end
            px_if.ready <= (pixel_stall == 0);
        end
    end

    initial begin
        int         counted;
        int         sent;
        logic [9:0] col;
        logic [9:0] row;
        logic [7:0] b;
        i_rst_n = 1'b0;
        rx_if.valid = 1'b0;
        rx_if.rx_byte = 8'd0;
        px_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_START_COLUMN;
        cfg_if.data = 10'd0;
        parser_mode = PARSE_IDLE;
        col_left = '0;
        row_left = '0;
        red_now = '0;
        green_now = '0;
        blue_now = '0;
        start_col_cfg = START_RESET;
        start_row_cfg = START_RESET;
        fail_count = 0;
        cycle_count = 0;
        pixel_stall = 0;
        calm_stretch = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < $size(script); i++) begin
            if (script[i].kind == ROW_SETUP) begin
                settle();
                set_starts(script[i].set_col, script[i].set_row);
            end else begin
                send_byte(script[i].rx, script[i].want, script[i].px);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    col = 10'd1023;
                    row = 10'd1023;
                end
                1: begin
                    col = 10'd0;
                    row = 10'd0;
                end
                2: begin
                    col = START_RESET;
                    row = START_RESET;
                end
                default: begin
                    if ($urandom_range(0, 2) == 0) begin
                        col = 10'($urandom);
                        row = 10'($urandom);
                    end else begin
                        col = 10'($urandom_range(0, 12));
                        row = 10'($urandom_range(0, 6));
                    end
                end
            endcase
            settle();
            set_starts(col, row);
            counted = 0;
            sent = 0;
            while (counted < PHASE_BYTES) begin
                if (sent % 40 == 0) begin
                    calm_stretch = ($urandom_range(0, 3) == 0);
                end
                b = pick_rx_byte();
                // Bytes dropped while waiting for a frame marker do not count.
                if (parser_mode != PARSE_IDLE || b == MARK_FRAME) begin
                    counted++;
                end
                sent++;
                send_byte(b, WANT_MODEL, NO_PX);
            end
        end

        settle();
        if (pending_pixels.size() != 0) begin
            $error("%0d expected pixels never arrived", pending_pixels.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/mpsp_pkg.sv
rtl/mpsp_if.sv
rtl/mpsp_cfg.sv
rtl/mpsp_core.sv
rtl/marked_pixel_stream_parser.sv
tb/marked_pixel_stream_parser_test.sv
